// ----- rtl/plml_pkg.sv -----
// Shared types and constants for the piecewise-linear map lookup block.
// Used by the divider and the top level. No dependencies.
`default_nettype none

package plml_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DATA_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int DIV_CNT_W  = $clog2(PROD_W + 1);
  localparam int ENTRY_W    = 2 * DATA_W;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int S_TDATA_W  = 56;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic REG_POINT_COUNT = 1'b0;

  localparam logic [CNT_W-1:0] POINT_COUNT_RESET = CNT_W'(MAX_POINTS);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MID   = 9'b000000010,
    ST_SCAN  = 9'b000000100,
    ST_CLAMP = 9'b000001000,
    ST_LOAD  = 9'b000010000,
    ST_MUL   = 9'b000100000,
    ST_DIVS  = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [PROD_W-1:0]     dividend;
    logic [DATA_W-1:0]     divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ----- rtl/plml_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module plml_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire  [$clog2(DEPTH)-1:0]  waddr,
  input  wire  [WIDTH-1:0]          wdata,
  input  wire  [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/plml_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on plml_pkg for widths and the request struct.
`default_nettype none

module plml_div (
  input  wire                             clk,
  input  wire                             rst,
  input  plml_pkg::div_req_t              req,
  output logic                            busy,
  output logic [plml_pkg::PROD_W-1:0]     quotient
);

  logic [plml_pkg::DIV_CNT_W-1:0] cnt;
  logic [plml_pkg::DATA_W-1:0]    rem;
  logic [plml_pkg::DATA_W-1:0]    divisor;
  logic [plml_pkg::DATA_W:0]      rem_sh;
  logic [plml_pkg::DATA_W:0]      rem_sub;
  logic                           ge;

  assign rem_sh  = {rem, quotient[plml_pkg::PROD_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign ge      = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= plml_pkg::DIV_CNT_W'(plml_pkg::PROD_W);
    end else if (busy) begin
      cnt <= cnt - plml_pkg::DIV_CNT_W'(1);
      if (cnt == plml_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quotient <= req.dividend;
      divisor  <= req.divisor;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[plml_pkg::PROD_W-2:0], ge};
      rem      <= ge ? rem_sub[plml_pkg::DATA_W-1:0] : rem_sh[plml_pkg::DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/piecewise_linear_map_lookup_top.sv -----
// Lookup: an end-clamped query ends after the table scan, an interpolated one also
// multiplies and divides; the 32-step serial divider dominates, and the table scan
// compares one breakpoint per step (at most half the table plus one).
// One word in flight: a write word every cycle while no lookup runs; the result
// register lets the next word enter while a result waits. Reset sets point_count to 16;
// the breakpoint table is undefined until written. Uses plml_pkg, plml_ram and plml_div.
`default_nettype none

module piecewise_linear_map_lookup_top (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // point_index[3:0], point_x[19:4], point_y[35:20], query_x[51:36], zero[55:52]
  input  wire  [plml_pkg::S_TDATA_W-1:0]    s_tdata,
  // opcode[0]
  input  wire                               s_tuser,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // interpolated_y[15:0]
  output logic [plml_pkg::DATA_W-1:0]       m_tdata,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [plml_pkg::PADDR_W-1:0]      paddr,
  input  wire  [plml_pkg::PDATA_W-1:0]      pwdata,
  output logic [plml_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  plml_pkg::state_t state, state_next;

  logic [plml_pkg::CNT_W-1:0]  point_count;
  logic [plml_pkg::CNT_W-1:0]  n_clamp;
  logic [plml_pkg::CNT_W-1:0]  n_pts;
  logic [plml_pkg::IDX_W-1:0]  idx;
  logic [plml_pkg::IDX_W-1:0]  scan_end;
  logic [plml_pkg::IDX_W-1:0]  mid;
  logic [plml_pkg::IDX_W-1:0]  last;
  logic [plml_pkg::IDX_W-1:0]  raddr;

  logic signed [plml_pkg::DATA_W-1:0] q;
  logic signed [plml_pkg::DATA_W-1:0] x_hi, y_hi, y_lo;
  logic signed [plml_pkg::DATA_W-1:0] dy, dq, dx;
  logic signed [plml_pkg::PROD_W-1:0] prod;
  logic        [plml_pkg::DATA_W-1:0] result;
  logic        [plml_pkg::DATA_W-1:0] quo_lo;
  logic                               neg;

  logic [plml_pkg::ENTRY_W-1:0]       rdata;
  logic signed [plml_pkg::DATA_W-1:0] rd_x, rd_y;
  logic                               q_le;
  logic                               s_accept;
  logic                               wr_en;
  logic                               cfg_wr;
  logic                               out_free;

  plml_pkg::div_req_t                 div_req;
  logic                               div_busy;
  logic [plml_pkg::PROD_W-1:0]        div_quo;

  assign s_tready = (state == plml_pkg::ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign wr_en    = s_accept && (s_tuser == plml_pkg::OP_WRITE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready
                    && (paddr[2] == plml_pkg::REG_POINT_COUNT);
  assign out_free = !m_tvalid || m_tready;

  assign rd_x = rdata[plml_pkg::DATA_W-1:0];
  assign rd_y = rdata[plml_pkg::ENTRY_W-1:plml_pkg::DATA_W];
  assign q_le = q <= rd_x;

  always_comb begin
    if (point_count == '0) begin
      n_clamp = plml_pkg::CNT_W'(1);
    end else if (point_count > plml_pkg::CNT_W'(plml_pkg::MAX_POINTS)) begin
      n_clamp = plml_pkg::CNT_W'(plml_pkg::MAX_POINTS);
    end else begin
      n_clamp = point_count;
    end
  end

  assign mid  = n_pts[plml_pkg::CNT_W-1:1];
  assign last = plml_pkg::IDX_W'(n_pts - plml_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= plml_pkg::POINT_COUNT_RESET;
    end else if (cfg_wr) begin
      point_count <= pwdata[plml_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == plml_pkg::REG_POINT_COUNT) begin
      prdata = plml_pkg::PDATA_W'(point_count);
    end
  end

  plml_ram #(
    .WIDTH (plml_pkg::ENTRY_W),
    .DEPTH (plml_pkg::MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s_tdata[3:0]),
    .wdata ({s_tdata[35:20], s_tdata[19:4]}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    raddr      = '0;
    unique case (state)
      plml_pkg::ST_IDLE: begin
        raddr = n_clamp[plml_pkg::CNT_W-1:1];
        if (s_accept && (s_tuser == plml_pkg::OP_LOOKUP)) begin
          state_next = plml_pkg::ST_MID;
        end
      end
      plml_pkg::ST_MID: begin
        raddr      = q_le ? '0 : mid;
        state_next = plml_pkg::ST_SCAN;
      end
      plml_pkg::ST_SCAN: begin
        if (q_le) begin
          raddr      = (idx == '0) ? '0 : idx - plml_pkg::IDX_W'(1);
          state_next = (idx == '0) ? plml_pkg::ST_CLAMP : plml_pkg::ST_LOAD;
        end else if (idx == scan_end) begin
          raddr      = last;
          state_next = plml_pkg::ST_CLAMP;
        end else begin
          raddr = idx + plml_pkg::IDX_W'(1);
        end
      end
      plml_pkg::ST_CLAMP: state_next = plml_pkg::ST_DONE;
      plml_pkg::ST_LOAD:  state_next = plml_pkg::ST_MUL;
      plml_pkg::ST_MUL:   state_next = plml_pkg::ST_DIVS;
      plml_pkg::ST_DIVS:  state_next = (dx == '0) ? plml_pkg::ST_DONE : plml_pkg::ST_DIV;
      plml_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_next = plml_pkg::ST_DONE;
        end
      end
      plml_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = plml_pkg::ST_IDLE;
        end
      end
      default: state_next = plml_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plml_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign quo_lo = neg ? plml_pkg::DATA_W'(-div_quo) : div_quo[plml_pkg::DATA_W-1:0];

  always_comb begin
    div_req.start    = (state == plml_pkg::ST_DIVS) && (dx != '0);
    div_req.dividend = prod[plml_pkg::PROD_W-1] ? plml_pkg::PROD_W'(-prod)
                                                : plml_pkg::PROD_W'(prod);
    div_req.divisor  = dx[plml_pkg::DATA_W-1] ? plml_pkg::DATA_W'(-dx)
                                              : plml_pkg::DATA_W'(dx);
  end

  plml_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    unique case (state)
      plml_pkg::ST_IDLE: begin
        q     <= s_tdata[51:36];
        n_pts <= n_clamp;
      end
      plml_pkg::ST_MID: begin
        idx      <= q_le ? '0 : mid;
        scan_end <= q_le ? mid : last;
      end
      plml_pkg::ST_SCAN: begin
        x_hi <= rd_x;
        y_hi <= rd_y;
        if (!q_le && (idx != scan_end)) begin
          idx <= idx + plml_pkg::IDX_W'(1);
        end
      end
      plml_pkg::ST_CLAMP: begin
        result <= rd_y;
      end
      plml_pkg::ST_LOAD: begin
        y_lo <= rd_y;
        dy   <= y_hi - rd_y;
        dq   <= q - rd_x;
        dx   <= x_hi - rd_x;
      end
      plml_pkg::ST_MUL: begin
        prod <= dy * dq;
      end
      plml_pkg::ST_DIVS: begin
        neg    <= prod[plml_pkg::PROD_W-1] ^ dx[plml_pkg::DATA_W-1];
        result <= y_lo;
      end
      plml_pkg::ST_DIV: begin
        if (!div_busy) begin
          result <= quo_lo + y_lo;
        end
      end
      plml_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == plml_pkg::ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == plml_pkg::ST_DONE) && out_free) begin
      m_tdata <= result;
    end
  end

`ifndef SYNTHESIS
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == plml_pkg::ST_DIV))
    else $error("divider busy outside divide state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == plml_pkg::ST_SCAN) |-> (idx <= scan_end))
    else $error("scan index past end of half");

  a_lookup_starts: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (s_tuser == plml_pkg::OP_LOOKUP)) |=> (state == plml_pkg::ST_MID))
    else $error("lookup did not start search");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (state == plml_pkg::ST_IDLE) && !div_busy)
    else $error("write word left idle state");
`endif

endmodule

`default_nettype wire
